### src/anas_pkg.sv
// Shared types and constants for the associative nearest above/below search core.
// No dependencies; imported by the core module and the testbench.
package anas_pkg;

	localparam int WORD_WIDTH  = 10;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int BIT_IDX_W   = $clog2(WORD_WIDTH);
	localparam int CFG_W       = 4;

	localparam logic [CFG_W-1:0] WORD_BITS_RESET = CFG_W'(WORD_WIDTH);

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_SEARCH  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]            func;
		logic [WORD_WIDTH-1:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic                  above_found;
		logic [WORD_WIDTH-1:0] above_word;
		logic                  below_found;
		logic [WORD_WIDTH-1:0] below_word;
		logic [CNT_W-1:0]      word_count;
	} out_item_t;

endpackage

### src/associative_nearest_above_below_search_core.sv
// Associative word store with bit-serial nearest-above / nearest-below search.
// Depends on anas_pkg for widths, codes, state and payload types.

// Usage: the store keeps a set of up to 64 distinct words, each entry a row of
// flip-flops with its own one-bit compare cell, so all entries are examined in
// parallel one bit per cycle, MSB first, over the active width n (word_bits
// clamped to 1..10). A search accepts, runs the key compare pass over n bits
// and the min/max extraction pass over n bits, then posts the result. A write
// runs the compare pass as a presence check; clear and the unused opcode only
// accept and post. One item is in work at a time; the result register lets the
// next item be accepted while a result waits to be taken. Reset empties the
// store. The user must write word_bits only while idle; no check enforces it.
module associative_nearest_above_below_search_core
	import anas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]      word_bits_q;
	logic [CFG_W-1:0]      nb;
	logic [BIT_IDX_W-1:0]  nb_m1;
	logic [WORD_WIDTH-1:0] mask;

	logic [1:0]            func_q;
	logic [WORD_WIDTH-1:0] key_q;
	logic [BIT_IDX_W-1:0]  bit_q;

	logic [WORD_WIDTH-1:0] words_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [STORE_DEPTH-1:0] gt_q, lt_q, gt_d, lt_d;
	logic [STORE_DEPTH-1:0] ca_q, cb_q, ca_d, cb_d;
	logic [STORE_DEPTH-1:0] wcol;
	logic [WORD_WIDTH-1:0]  above_sh_q, below_sh_q;
	logic                   kbit, any0, any1;

	logic      out_valid_q;
	out_item_t out_q, res;

	logic accept, out_free, last_bit;
	logic cmp_en, ext_en, fin_en;
	logic present, full, do_store;

	// active width, clamped to 1..WORD_WIDTH
	always_comb begin
		if (word_bits_q == '0) begin
			nb = CFG_W'(1);
		end else if (word_bits_q > CFG_W'(WORD_WIDTH)) begin
			nb = CFG_W'(WORD_WIDTH);
		end else begin
			nb = word_bits_q;
		end
	end

	assign nb_m1    = BIT_IDX_W'(nb - CFG_W'(1));
	assign mask     = ~({WORD_WIDTH{1'b1}} << nb);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign last_bit = (bit_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bits_q <= WORD_BITS_RESET;
		end else if (cfg_we) begin
			word_bits_q <= cfg_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.func == FUNC_WRITE || in_data.func == FUNC_SEARCH) begin
						state_d = ST_CMP;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_CMP: begin
				if (last_bit) begin
					state_d = (func_q == FUNC_SEARCH) ? ST_EXT : ST_FIN;
				end
			end
			ST_EXT: begin
				if (last_bit) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		cmp_en   = 1'b0;
		ext_en   = 1'b0;
		fin_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CMP:  cmp_en   = 1'b1;
			ST_EXT:  ext_en   = 1'b1;
			ST_FIN:  fin_en   = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bit column of all entries at the current bit position
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_col
		assign wcol[i] = words_q[i][bit_q];
	end

	assign kbit = key_q[bit_q];

	// compare cells: latch greater/less at the first differing bit
	assign gt_d = gt_q | (~gt_q & ~lt_q & wcol & ~{STORE_DEPTH{kbit}});
	assign lt_d = lt_q | (~gt_q & ~lt_q & ~wcol & {STORE_DEPTH{kbit}});

	// extraction: keep candidates with a 0 (min) or a 1 (max) when any have one
	assign any0 = |(ca_q & ~wcol);
	assign any1 = |(cb_q & wcol);
	assign ca_d = any0 ? (ca_q & ~wcol) : ca_q;
	assign cb_d = any1 ? (cb_q & wcol) : cb_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_data.func;
			key_q  <= in_data.data_word & mask;
			bit_q  <= nb_m1;
			gt_q   <= '0;
			lt_q   <= '0;
		end else if (cmp_en) begin
			gt_q <= gt_d;
			lt_q <= lt_d;
			if (last_bit) begin
				bit_q      <= nb_m1;
				ca_q       <= valid_q & ~lt_d;
				cb_q       <= valid_q & ~gt_d;
				above_sh_q <= '0;
				below_sh_q <= '0;
			end else begin
				bit_q <= bit_q - BIT_IDX_W'(1);
			end
		end else if (ext_en) begin
			ca_q       <= ca_d;
			cb_q       <= cb_d;
			above_sh_q <= {above_sh_q[WORD_WIDTH-2:0], !any0};
			below_sh_q <= {below_sh_q[WORD_WIDTH-2:0], any1};
			if (!last_bit) begin
				bit_q <= bit_q - BIT_IDX_W'(1);
			end
		end
	end

	assign present  = |(valid_q & ~gt_q & ~lt_q);
	assign full     = (cnt_q == CNT_W'(STORE_DEPTH));
	assign do_store = fin_en && (func_q == FUNC_WRITE) && !present && !full;

	always_comb begin
		res = '0;
		res.word_count = cnt_q;
		case (func_q)
			FUNC_CLEAR: begin
				res.status     = STAT_DONE;
				res.word_count = '0;
			end
			FUNC_WRITE: begin
				if (present) begin
					res.status = STAT_PRESENT;
				end else if (full) begin
					res.status = STAT_FULL;
				end else begin
					res.status     = STAT_DONE;
					res.word_count = cnt_q + CNT_W'(1);
				end
			end
			FUNC_SEARCH: begin
				res.status      = STAT_SEARCH;
				res.above_found = |ca_q;
				res.above_word  = above_sh_q;
				res.below_found = |cb_q;
				res.below_word  = below_sh_q;
			end
			default: res.status = STAT_DONE;
		endcase
	end

	// store rows hold no reset; valid bits gate every use
	always_ff @(posedge clk) begin
		if (do_store) begin
			words_q[cnt_q[ADDR_W-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (fin_en && func_q == FUNC_CLEAR) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (do_store) begin
			valid_q[cnt_q[ADDR_W-1:0]] <= 1'b1;
			cnt_q                      <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_en) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// entries fill in order, so the valid bits always match the fill count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("valid bits disagree with entry count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STORE_DEPTH))
		else $error("entry count beyond store depth");

	a_cand_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXT) && (|ca_q) |=> (|ca_q))
		else $error("above candidate set emptied during extraction");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == STAT_SEARCH) && out_q.above_found
			&& out_q.below_found |-> (out_q.below_word <= out_q.above_word))
		else $error("nearest below exceeds nearest above");

endmodule

### test/associative_nearest_above_below_search_core_test.sv
// Testbench for associative_nearest_above_below_search_core: drives clear, write and search
// transfers over valid/ready and checks every result against a scoreboard model.
// Depends on anas_pkg for payload types, codes and widths.
`timescale 1ns / 100ps

module associative_nearest_above_below_search_core_test;
	import anas_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	class search_scoreboard;
		logic [WORD_WIDTH-1:0] words [STORE_DEPTH];
		bit                    occupied [STORE_DEPTH];
		int unsigned           held;
		logic [CFG_W-1:0]      width_cfg;
		out_item_t             pending [$];
		int unsigned           errors;

		function new();
			foreach (occupied[i]) occupied[i] = 1'b0;
			held      = 0;
			width_cfg = WORD_BITS_RESET;
			errors    = 0;
		endfunction

		function void set_word_bits(logic [CFG_W-1:0] value);
			width_cfg = value;
		endfunction

		// clamp the width to 1..WORD_WIDTH
		function logic [WORD_WIDTH-1:0] width_mask();
			int bits;
			bits = int'(width_cfg);
			if (bits < 1) bits = 1;
			if (bits > WORD_WIDTH) bits = WORD_WIDTH;
			return WORD_WIDTH'((1 << bits) - 1);
		endfunction

		function void note_request(in_item_t req);
			logic [WORD_WIDTH-1:0] mask;
			logic [WORD_WIDTH-1:0] key;
			logic [WORD_WIDTH-1:0] w;
			out_item_t             rsp;
			int                    slot;
			bit                    present;
			mask    = width_mask();
			key     = req.data_word & mask;
			rsp     = '0;
			slot    = -1;
			present = 1'b0;
			case (req.func)
				FUNC_CLEAR: begin
					foreach (occupied[i]) occupied[i] = 1'b0;
					held       = 0;
					rsp.status = STAT_DONE;
				end
				FUNC_WRITE: begin
					foreach (occupied[i])
						if (occupied[i] && (words[i] & mask) == key) present = 1'b1;
					if (present) begin
						rsp.status = STAT_PRESENT;
					end else begin
						foreach (occupied[i])
							if (!occupied[i] && slot < 0) slot = i;
						if (slot < 0) begin
							rsp.status = STAT_FULL;
						end else begin
							words[slot]    = key;
							occupied[slot] = 1'b1;
							held++;
							rsp.status     = STAT_DONE;
						end
					end
				end
				FUNC_SEARCH: begin
					rsp.status     = STAT_SEARCH;
					rsp.above_word = mask;
					rsp.below_word = '0;
					foreach (occupied[i]) begin
						if (occupied[i]) begin
							w = words[i] & mask;
							if (w >= key && (!rsp.above_found || w < rsp.above_word)) begin
								rsp.above_word  = w;
								rsp.above_found = 1'b1;
							end
							if (w <= key && (!rsp.below_found || w > rsp.below_word)) begin
								rsp.below_word  = w;
								rsp.below_found = 1'b1;
							end
						end
					end
				end
				default: begin
					rsp.status = STAT_DONE;
				end
			endcase
			rsp.word_count = CNT_W'(held);
			pending = {pending, rsp};
		endfunction

		function void check_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check_response(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				$error("result with nothing outstanding: status %0d", got.status);
				errors++;
				return;
			end
			exp = pending.pop_front();
			check_field("status", 32'(exp.status), 32'(got.status));
			check_field("above_found", 32'(exp.above_found), 32'(got.above_found));
			check_field("above_word", 32'(exp.above_word), 32'(got.above_word));
			check_field("below_found", 32'(exp.below_found), 32'(got.below_found));
			check_field("below_word", 32'(exp.below_word), 32'(got.below_word));
			check_field("word_count", 32'(exp.word_count), 32'(got.word_count));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_data;

	search_scoreboard       sb;
	int                     idle_pct;
	int                     stall_pct;
	int                     hold_len;
	logic [WORD_WIDTH-1:0]  recent [$];

	associative_nearest_above_below_search_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				hold_len--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// sample between edges; the transfer completes at the following rising edge
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) sb.check_response(out_data);
		end
	end

	task automatic send_item(input logic [1:0] func, input logic [WORD_WIDTH-1:0] word);
		in_item_t req;
		bit       taken;
		req.func      = func;
		req.data_word = word;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		sb.note_request(req);
		if (func == FUNC_WRITE) begin
			recent = {recent, word};
			if (recent.size() > 16) void'(recent.pop_front());
		end
	endtask

	// mostly fresh values, some near recently written words to hit matches
	task automatic send_random();
		int                    pick;
		logic [1:0]            func;
		logic [WORD_WIDTH-1:0] word;
		pick = $urandom_range(99);
		if (pick < 3) func = FUNC_UNUSED;
		else if (pick < 7) func = FUNC_CLEAR;
		else if (pick < 52) func = FUNC_WRITE;
		else func = FUNC_SEARCH;
		if (recent.size() > 0 && $urandom_range(3) == 0)
			word = WORD_WIDTH'(recent[$urandom_range(recent.size() - 1)]
				+ $urandom_range(2) - 1);
		else
			word = WORD_WIDTH'($urandom_range(1023));
		send_item(func, word);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_random();
	endtask

	// stride 37 is odd, so up to 2^n consecutive words stay distinct under an n-bit width mask
	task automatic fill_store(input int count);
		logic [WORD_WIDTH-1:0] base;
		base = WORD_WIDTH'($urandom_range(1023));
		send_item(FUNC_CLEAR, WORD_WIDTH'($urandom_range(1023)));
		for (int i = 0; i < count; i++) send_item(FUNC_WRITE, base + WORD_WIDTH'(i * 37));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_width(input logic [CFG_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_word_bits(value);
		@(posedge clk);
	endtask

	task automatic set_idling(input int sender, input int receiver);
		idle_pct  = sender;
		stall_pct = receiver;
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_len  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_width(4'd10);
		set_idling(0, 0);
		// empty store, extremes, duplicate, alternating patterns, unused opcode
		send_item(FUNC_SEARCH, 10'd0);
		send_item(FUNC_SEARCH, 10'd1023);
		send_item(FUNC_WRITE, 10'd0);
		send_item(FUNC_WRITE, 10'd1023);
		send_item(FUNC_WRITE, 10'd0);
		send_item(FUNC_WRITE, 10'd512);
		send_item(FUNC_SEARCH, 10'd0);
		send_item(FUNC_SEARCH, 10'd1023);
		send_item(FUNC_SEARCH, 10'd511);
		send_item(FUNC_SEARCH, 10'd512);
		send_item(FUNC_SEARCH, 10'd513);
		send_item(FUNC_WRITE, 10'd341);
		send_item(FUNC_WRITE, 10'd682);
		send_item(FUNC_SEARCH, 10'd340);
		send_item(FUNC_SEARCH, 10'd683);
		send_item(FUNC_UNUSED, 10'd1023);
		send_item(FUNC_UNUSED, 10'd0);
		send_item(FUNC_SEARCH, 10'd600);
		send_item(FUNC_CLEAR, 10'd1023);
		send_item(FUNC_SEARCH, 10'd512);
		send_item(FUNC_WRITE, 10'd5);
		send_item(FUNC_SEARCH, 10'd5);
		send_item(FUNC_SEARCH, 10'd4);
		send_item(FUNC_SEARCH, 10'd6);

		// full store, then narrow the width without clearing
		fill_store(70);
		run_random(40);
		write_width(4'd4);
		set_idling(52, 0);
		run_random(80);

		write_width(4'd1);
		set_idling(0, 52);
		run_random(80);

		write_width(4'd0);
		set_idling(18, 18);
		run_random(60);

		write_width(4'd15);
		set_idling(0, 0);
		run_random(20);
		hold_len = 300;
		run_random(60);

		write_width(4'd7);
		set_idling(52, 0);
		fill_store(70);
		run_random(20);
		drain();
		run_random(30);

		write_width(4'd10);
		set_idling(18, 18);
		run_random(100);

		drain();
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
